@@ src/source_lexer_defines.svh @@
// Assertion macros shared by the source lexer checkers.
// Needs nothing else; included by files that hold concurrent assertions.
`ifndef SOURCE_LEXER_DEFINES_SVH
`define SOURCE_LEXER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SLX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SLX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/slx_pkg.sv @@
// Source lexer package: item types, token kinds, lexer modes, byte classes.
// No dependencies; imported by every module of the block.
package slx_pkg;

  localparam int OFFSET_BITS_DEF = 24;
  localparam int LENGTH_BITS_DEF = 16;

  localparam int KIND_W  = 5;
  localparam int START_W = 24;
  localparam int LEN_W   = 16;

  localparam int QUEUE_DEPTH = 4;

  typedef logic [KIND_W-1:0] slx_kind_t;

  localparam slx_kind_t KIND_KEYWORD = 5'd0;
  localparam slx_kind_t KIND_ARROW   = 5'd1;
  localparam slx_kind_t KIND_STRING  = 5'd2;
  localparam slx_kind_t KIND_IDENT   = 5'd3;
  localparam slx_kind_t KIND_INT     = 5'd4;
  localparam slx_kind_t KIND_ASSIGN  = 5'd5;
  localparam slx_kind_t KIND_PLUS    = 5'd6;
  localparam slx_kind_t KIND_MINUS   = 5'd7;
  localparam slx_kind_t KIND_PERCENT = 5'd8;
  localparam slx_kind_t KIND_STAR    = 5'd9;
  localparam slx_kind_t KIND_SLASH   = 5'd10;
  localparam slx_kind_t KIND_COLON   = 5'd11;
  localparam slx_kind_t KIND_COMMA   = 5'd12;
  localparam slx_kind_t KIND_LBRACE  = 5'd13;
  localparam slx_kind_t KIND_RBRACE  = 5'd14;
  localparam slx_kind_t KIND_LBRACK  = 5'd15;
  localparam slx_kind_t KIND_RBRACK  = 5'd16;
  localparam slx_kind_t KIND_LPAREN  = 5'd17;
  localparam slx_kind_t KIND_RPAREN  = 5'd18;
  localparam slx_kind_t KIND_LTEQ    = 5'd19;
  localparam slx_kind_t KIND_LT      = 5'd20;
  localparam slx_kind_t KIND_GTEQ    = 5'd21;
  localparam slx_kind_t KIND_GT      = 5'd22;
  localparam slx_kind_t KIND_ERROR   = 5'd23;

  // keyword slots, also bit positions in the live mask
  localparam logic [1:0] KW_IF     = 2'd0;
  localparam logic [1:0] KW_ELSE   = 2'd1;
  localparam logic [1:0] KW_RETURN = 2'd2;
  localparam int         KW_NUM    = 3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } slx_in_t;

  typedef struct packed {
    slx_kind_t          token_kind;
    logic [START_W-1:0] token_start;
    logic [LEN_W-1:0]   token_length;
    logic               last_of_run;
  } slx_out_t;

  // up to two tokens per byte; vld[1] implies vld[0]
  typedef struct packed {
    logic [1:0] vld;
    slx_out_t   first;
    slx_out_t   second;
  } slx_res_pair_t;

  typedef enum logic [6:0] {
    MODE_IDLE   = 7'b000_0001,
    MODE_WORD   = 7'b000_0010,
    MODE_NUMBER = 7'b000_0100,
    MODE_STRING = 7'b000_1000,
    MODE_MINUS  = 7'b001_0000,
    MODE_LT     = 7'b010_0000,
    MODE_GT     = 7'b100_0000
  } slx_mode_t;

  typedef struct packed {
    logic      hit;
    slx_kind_t kind;
  } slx_op_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h0D || c == 8'h0A;
  endfunction

  // single-byte operators and brackets; minus, < and > go through pair modes
  function automatic slx_op_t op_lookup(input logic [7:0] c);
    slx_op_t op;
    op.hit  = 1'b1;
    op.kind = KIND_ERROR;
    case (c)
      "=":     op.kind = KIND_ASSIGN;
      "+":     op.kind = KIND_PLUS;
      "%":     op.kind = KIND_PERCENT;
      "*":     op.kind = KIND_STAR;
      "/":     op.kind = KIND_SLASH;
      ":":     op.kind = KIND_COLON;
      ",":     op.kind = KIND_COMMA;
      "{":     op.kind = KIND_LBRACE;
      "}":     op.kind = KIND_RBRACE;
      "[":     op.kind = KIND_LBRACK;
      "]":     op.kind = KIND_RBRACK;
      "(":     op.kind = KIND_LPAREN;
      ")":     op.kind = KIND_RPAREN;
      default: op.hit  = 1'b0;
    endcase
    return op;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] n;
    case (k)
      KW_IF:     n = 3'd2;
      KW_ELSE:   n = 3'd4;
      KW_RETURN: n = 3'd6;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      KW_IF: begin
        case (idx)
          3'd0:    ch = "i";
          3'd1:    ch = "f";
          default: ch = 8'h00;
        endcase
      end
      KW_ELSE: begin
        case (idx)
          3'd0:    ch = "e";
          3'd1:    ch = "l";
          3'd2:    ch = "s";
          3'd3:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      KW_RETURN: begin
        case (idx)
          3'd0:    ch = "r";
          3'd1:    ch = "e";
          3'd2:    ch = "t";
          3'd3:    ch = "u";
          3'd4:    ch = "r";
          3'd5:    ch = "n";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ src/slx_step.sv @@
// Lexer state registers and the per-byte next-state and token logic.
// Depends on slx_pkg.
module slx_step import slx_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  slx_in_t       item,
  output slx_res_pair_t res
);

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

  slx_mode_t              mode_r, mode_mid, mode_nxt;
  logic [OFFSET_BITS-1:0] origin_r, origin_mid, origin_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_mid, count_nxt;
  logic [KW_NUM-1:0]      kw_r, kw_mid, kw_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt, pos_inc;

  logic [7:0]             c;
  logic                   last;
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic [KW_NUM-1:0]      live, kw_done;

  // token begun from idle
  slx_mode_t              sb_mode;
  logic [LENGTH_BITS-1:0] sb_count;
  logic [KW_NUM-1:0]      sb_kw;
  logic                   sb_hit;
  slx_kind_t              sb_kind;
  slx_op_t                op;

  // a: token closed by this byte, b: single-byte token, f: flush at end
  logic                   a_hit, take_sb, b_hit, f_hit, g_hit;
  slx_kind_t              a_kind, f_kind;
  logic [OFFSET_BITS-1:0] a_start;
  logic [LENGTH_BITS-1:0] a_len, f_len;
  slx_out_t               a_tok, b_tok, f_tok, g_tok;

  assign c       = item.char_code;
  assign last    = item.end_of_input;
  assign pos_inc = (pos_r == OFFSET_MAX) ? pos_r : pos_r + 1'b1;
  assign cnt_inc = (count_r == LENGTH_MAX) ? count_r : count_r + 1'b1;

  always_comb begin
    for (int k = 0; k < KW_NUM; k++) begin
      live[k]    = kw_r[k] && (count_r < LENGTH_BITS'(kw_len(2'(k))))
                   && (c == kw_char(2'(k), count_r[2:0]));
      kw_done[k] = live[k] && (cnt_inc == LENGTH_BITS'(kw_len(2'(k))));
    end
  end

  always_comb begin
    op       = op_lookup(c);
    sb_mode  = MODE_IDLE;
    sb_count = LENGTH_BITS'(1);
    sb_kw    = '0;
    sb_hit   = 1'b0;
    sb_kind  = KIND_ERROR;
    if (is_blank(c)) begin
      sb_count = '0;
    end else if (is_alpha(c)) begin
      sb_mode = MODE_WORD;
      sb_kw   = {c == "r", c == "e", c == "i"};
    end else if (is_digit(c)) begin
      sb_mode = MODE_NUMBER;
    end else if (c == 8'h22) begin
      sb_mode = MODE_STRING;
    end else if (c == "-") begin
      sb_mode = MODE_MINUS;
    end else if (c == "<") begin
      sb_mode = MODE_LT;
    end else if (c == ">") begin
      sb_mode = MODE_GT;
    end else begin
      sb_hit   = 1'b1;
      sb_count = '0;
      sb_kind  = op.hit ? op.kind : KIND_ERROR;
    end
  end

  always_comb begin
    mode_mid   = mode_r;
    origin_mid = origin_r;
    count_mid  = count_r;
    kw_mid     = kw_r;
    a_hit      = 1'b0;
    a_kind     = KIND_ERROR;
    a_start    = origin_r;
    a_len      = count_r;
    take_sb    = 1'b0;
    unique case (mode_r) inside
      MODE_WORD: begin
        if (!(is_alpha(c) || is_digit(c))) begin
          a_hit   = 1'b1;
          a_kind  = KIND_IDENT;
          take_sb = 1'b1;
        end else begin
          count_mid = cnt_inc;
          kw_mid    = live;
          if (|kw_done) begin
            a_hit     = 1'b1;
            a_kind    = KIND_KEYWORD;
            a_len     = cnt_inc;
            mode_mid  = MODE_IDLE;
            count_mid = '0;
            kw_mid    = '0;
          end
        end
      end
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          count_mid = cnt_inc;
        end else begin
          a_hit   = 1'b1;
          a_kind  = KIND_INT;
          take_sb = 1'b1;
        end
      end
      MODE_STRING: begin
        count_mid = cnt_inc;
        if (c == 8'h22) begin
          a_hit     = 1'b1;
          a_kind    = KIND_STRING;
          a_len     = cnt_inc;
          mode_mid  = MODE_IDLE;
          count_mid = '0;
        end
      end
      MODE_MINUS, MODE_LT, MODE_GT: begin
        a_hit = 1'b1;
        if ((mode_r == MODE_MINUS && c == ">") || (mode_r != MODE_MINUS && c == "=")) begin
          a_kind    = (mode_r == MODE_MINUS) ? KIND_ARROW :
                      (mode_r == MODE_LT) ? KIND_LTEQ : KIND_GTEQ;
          a_len     = LENGTH_BITS'(2);
          mode_mid  = MODE_IDLE;
          count_mid = '0;
        end else begin
          a_kind  = (mode_r == MODE_MINUS) ? KIND_MINUS :
                    (mode_r == MODE_LT) ? KIND_LT : KIND_GT;
          a_len   = LENGTH_BITS'(1);
          take_sb = 1'b1;
        end
      end
      default: take_sb = 1'b1;
    endcase
    if (take_sb) begin
      mode_mid   = sb_mode;
      origin_mid = pos_r;
      count_mid  = sb_count;
      kw_mid     = sb_kw;
    end
  end

  assign b_hit = take_sb && sb_hit;

  // end of input closes whatever is still pending after this byte
  always_comb begin
    f_hit  = last;
    f_kind = KIND_ERROR;
    f_len  = count_mid;
    unique case (mode_mid)
      MODE_WORD:   f_kind = KIND_IDENT;
      MODE_NUMBER: f_kind = KIND_INT;
      MODE_STRING: f_kind = KIND_ERROR;
      MODE_MINUS: begin
        f_kind = KIND_MINUS;
        f_len  = LENGTH_BITS'(1);
      end
      MODE_LT: begin
        f_kind = KIND_LT;
        f_len  = LENGTH_BITS'(1);
      end
      MODE_GT: begin
        f_kind = KIND_GT;
        f_len  = LENGTH_BITS'(1);
      end
      default: f_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (last) begin
      mode_nxt   = MODE_IDLE;
      origin_nxt = '0;
      count_nxt  = '0;
      kw_nxt     = '0;
      pos_nxt    = '0;
    end else begin
      mode_nxt   = mode_mid;
      origin_nxt = origin_mid;
      count_nxt  = count_mid;
      kw_nxt     = kw_mid;
      pos_nxt    = pos_inc;
    end
  end

  always_comb begin
    a_tok.token_kind   = a_kind;
    a_tok.token_start  = START_W'(a_start);
    a_tok.token_length = LEN_W'(a_len);
    a_tok.last_of_run  = 1'b0;

    b_tok.token_kind   = sb_kind;
    b_tok.token_start  = START_W'(pos_r);
    b_tok.token_length = LEN_W'(1);
    b_tok.last_of_run  = 1'b1;

    f_tok.token_kind   = f_kind;
    f_tok.token_start  = START_W'(origin_mid);
    f_tok.token_length = LEN_W'(f_len);
    f_tok.last_of_run  = 1'b1;

    // a single-byte token leaves nothing pending, so b and f never meet
    g_hit = b_hit || f_hit;
    g_tok = b_hit ? b_tok : f_tok;

    res.vld    = {a_hit && g_hit, a_hit || g_hit};
    res.first  = a_hit ? a_tok : g_tok;
    res.second = g_tok;
    res.first.last_of_run = !(a_hit && g_hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      origin_r <= '0;
      count_r  <= '0;
      kw_r     <= '0;
      pos_r    <= '0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      origin_r <= origin_nxt;
      count_r  <= count_nxt;
      kw_r     <= kw_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

@@ src/slx_outq.sv @@
// Token queue: takes up to two tokens a cycle, hands out one a cycle while out_stall is low.
// Depends on slx_pkg.
module slx_outq import slx_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_en,
  input  slx_res_pair_t push,
  output logic          room,
  output logic          out_valid,
  input  logic          out_stall,
  output slx_out_t      out_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  slx_out_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_second;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, n_push;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_r];
  assign room      = (cnt_r <= CNT_W'(QUEUE_DEPTH - 2));
  assign pop       = out_valid && !out_stall;
  assign wr_second = wr_r + 1'b1;

  always_comb begin
    n_push  = push_en ? (CNT_W'(push.vld[0]) + CNT_W'(push.vld[1])) : '0;
    wr_nxt  = wr_r + PTR_W'(n_push);
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + n_push - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (push_en && push.vld[0] && wr_r == PTR_W'(i)) begin
        mem_r[i] <= push.first;
      end else if (push_en && push.vld[1] && wr_second == PTR_W'(i)) begin
        mem_r[i] <= push.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ src/source_lexer.sv @@
// source_lexer: streaming lexer, one source byte per item in, one token per item out
// (uses slx_pkg, slx_step, slx_outq). Bytes are taken one per clock while in_stall is
// low; a byte lands in an input register, and once the queue has room the lexer step
// runs it and drops the zero, one or two tokens it closes into a four-entry token
// queue, which drives out_data. Sustained rate is one byte per cycle for as long as
// bytes close at most one token each and out_stall stays low; a byte that closes two
// tokens (an identifier ended by a bracket, say) queues both while the result port
// hands out one at a time, and in_stall rises while a byte is held and the queue has
// fewer than two free slots.
// Tokens carry kind, start offset and length; offsets saturate at
// 2^OFFSET_BITS-1 and lengths at 2^LENGTH_BITS-1. A byte with end_of_input set
// flushes any pending token and puts the offset back to zero for the next stream.
// last_of_run marks the final token caused by a byte.
module source_lexer import slx_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  slx_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output slx_out_t out_data
);

  // input register
  logic          in_vld_r, in_vld_nxt;
  slx_in_t       in_item_r;

  logic          accept;
  logic          advance;
  logic          room;
  slx_res_pair_t res;

  // the held byte moves on only when the queue can take two tokens
  assign advance  = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign accept   = in_valid && !in_stall;

  assign in_vld_nxt = accept || (in_vld_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_data;
    end
  end

  // lexer state and token decision for the held byte
  slx_step #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (in_item_r),
    .res   (res)
  );

  // token queue doubles as the result register
  slx_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (advance),
    .push      (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ src/slx_checker.sv @@
// Port-level checks for source_lexer, attached by bind.
// Depends on slx_pkg and source_lexer_defines.svh.
`include "source_lexer_defines.svh"

module slx_checker import slx_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input slx_out_t out_data
);

  `SLX_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled token changed")

  // both tokens of a byte are queued together, so a run never breaks
  `SLX_ASSERT_NEXT(a_run_whole, clk, rst_n, out_valid && !out_stall && !out_data.last_of_run, out_valid, "token run broken")

  `SLX_ASSERT_IMPL(a_kw_len, clk, rst_n, out_valid && out_data.token_kind == KIND_KEYWORD, out_data.token_length == 16'd2 || out_data.token_length == 16'd4 || out_data.token_length == 16'd6, "bad keyword length")

  `SLX_ASSERT_IMPL(a_pair_len, clk, rst_n, out_valid && (out_data.token_kind == KIND_ARROW || out_data.token_kind == KIND_LTEQ || out_data.token_kind == KIND_GTEQ), out_data.token_length == 16'd2, "bad two-byte operator length")

endmodule

bind source_lexer slx_checker u_slx_checker (.*);
